// ----- hdl/subtitle_cue_stream_parser_assert.svh -----
// Assertion macros shared by the subtitle cue stream parser RTL.
`ifndef SUBTITLE_CUE_STREAM_PARSER_ASSERT_SVH
`define SUBTITLE_CUE_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SCP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/scp_pkg.sv -----
// Types, constants and the time weight table of the subtitle cue stream parser.
package scp_pkg;

   localparam logic [7:0] NEWLINE    = 8'd10;
   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [5:0] COLUMN_MAX = 6'd63;
   localparam int END_TIME_COLUMN    = 17;
   localparam int TIME_FIELD_LEN     = 12;
   localparam int QUEUE_DEPTH_DEF    = 2;
   localparam int ID_W               = 32;
   localparam int MS_W               = 29;

   typedef enum logic [1:0] {
      PHASE_ID,
      PHASE_TIME,
      PHASE_TEXT
   } phase_type;

   typedef enum logic [2:0] {
      OP_TEXT,
      OP_LINE_END,
      OP_CUE,
      OP_ID_DIGIT,
      OP_TIME
   } op_type;

   typedef enum logic [1:0] {
      KIND_TEXT,
      KIND_LINE_END,
      KIND_CUE
   } kind_type;

   // Work item handed from the front to the back.
   typedef struct packed {
      op_type            op;
      logic [7:0]        ch;
      logic [3:0]        digit;
      logic [MS_W-1:0]   start_add;
      logic [MS_W-1:0]   end_add;
   } cmd_type;

   typedef struct packed {
      kind_type          kind;
      logic [7:0]        text_char;
      logic [ID_W-1:0]   cue_number;
      logic [MS_W-1:0]   start_ms;
      logic [MS_W-1:0]   end_ms;
   } rsp_type;

   // Millisecond weight of a digit at each place of "hh:mm:ss,mmm".
   function automatic logic [25:0] time_weight(input logic [3:0] idx);
      logic [25:0] w;
      unique case (idx)
         4'd0:    w = 26'd36000000;
         4'd1:    w = 26'd3600000;
         4'd3:    w = 26'd600000;
         4'd4:    w = 26'd60000;
         4'd6:    w = 26'd10000;
         4'd7:    w = 26'd1000;
         4'd9:    w = 26'd100;
         4'd10:   w = 26'd10;
         4'd11:   w = 26'd1;
         default: w = 26'd0;
      endcase
      return w;
   endfunction

endpackage

// ----- hdl/scp_fifo.sv -----
// Small first-in first-out queue of packed items.
module scp_fifo
   import scp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ----- hdl/scp_front.sv -----
// Front end: tracks line phase and column; some bytes become work items.
module scp_front
   import scp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  logic [7:0] char_in,
   input  logic       queue_full,
   output logic       enq,
   output cmd_type    cmd
);

   localparam logic [5:0] END_COL  = 6'(END_TIME_COLUMN);
   localparam logic [5:0] FIELD_LEN = 6'(TIME_FIELD_LEN);

   phase_type  phase_ff, phase_in;
   logic [5:0] column_ff, column_in;
   logic       accept;
   logic       is_digit;
   logic [3:0] digit;
   logic [5:0] end_off;
   logic [3:0] start_idx, end_idx;
   logic       start_hit, end_hit;
   logic [29:0] start_prod, end_prod;

   assign accept    = push && !queue_full;
   assign is_digit  = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign digit     = 4'(char_in - CHAR_ZERO);
   assign end_off   = column_ff - END_COL;
   assign start_hit = (column_ff < FIELD_LEN);
   assign end_hit   = (column_ff >= END_COL) && (end_off < FIELD_LEN);
   assign start_idx = column_ff[3:0];
   assign end_idx   = end_off[3:0];
   assign start_prod = start_hit ? 30'(digit) * 30'(time_weight(start_idx)) : '0;
   assign end_prod   = end_hit   ? 30'(digit) * 30'(time_weight(end_idx))   : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_ID;
         column_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         column_ff <= column_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      column_in     = column_ff;
      enq           = 1'b0;
      cmd.op        = OP_TEXT;
      cmd.ch        = char_in;
      cmd.digit     = digit;
      cmd.start_add = start_prod[MS_W-1:0];
      cmd.end_add   = end_prod[MS_W-1:0];
      if (accept) begin
         if (char_in == NEWLINE) begin
            if (column_ff == '0) begin
               // empty line closes the cue
               enq      = 1'b1;
               cmd.op   = OP_CUE;
               phase_in = PHASE_ID;
            end else begin
               column_in = '0;
               unique case (phase_ff)
                  PHASE_TIME: phase_in = PHASE_TEXT;
                  PHASE_TEXT: begin
                     enq    = 1'b1;
                     cmd.op = OP_LINE_END;
                  end
                  default:    phase_in = PHASE_TIME;
               endcase
            end
         end else begin
            if (column_ff != COLUMN_MAX) begin
               column_in = column_ff + 1'b1;
            end
            unique case (phase_ff)
               PHASE_TEXT: enq = 1'b1;
               PHASE_TIME: begin
                  enq    = is_digit && (start_hit || end_hit);
                  cmd.op = OP_TIME;
               end
               default: begin
                  enq    = is_digit;
                  cmd.op = OP_ID_DIGIT;
               end
            endcase
         end
      end
   end

endmodule

// ----- hdl/scp_back.sv -----
// Back end: gathers cue id and times, builds result items.
module scp_back
   import scp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    queue_empty,
   input  cmd_type cmd,
   output logic    queue_pop,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp
);

   logic [ID_W-1:0] id_ff, id_in;
   logic [MS_W-1:0] start_ff, start_in;
   logic [MS_W-1:0] end_ff, end_in;
   logic [ID_W+3:0] id_x10;
   logic            run;

   assign run    = !queue_empty && !rsp_full;
   assign id_x10 = ({4'b0, id_ff} << 3) + ({4'b0, id_ff} << 1) + (ID_W + 4)'(cmd.digit);

   always_comb begin
      queue_pop      = run;
      rsp_push       = 1'b0;
      id_in          = id_ff;
      start_in       = start_ff;
      end_in         = end_ff;
      rsp.kind       = KIND_TEXT;
      rsp.text_char  = '0;
      rsp.cue_number = '0;
      rsp.start_ms   = '0;
      rsp.end_ms     = '0;
      if (run) begin
         unique case (cmd.op)
            OP_TEXT: begin
               rsp_push      = 1'b1;
               rsp.text_char = cmd.ch;
            end
            OP_LINE_END: begin
               rsp_push = 1'b1;
               rsp.kind = KIND_LINE_END;
            end
            OP_CUE: begin
               rsp_push       = 1'b1;
               rsp.kind       = KIND_CUE;
               rsp.cue_number = id_ff;
               rsp.start_ms   = start_ff;
               rsp.end_ms     = end_ff;
               id_in          = '0;
               start_in       = '0;
               end_in         = '0;
            end
            OP_ID_DIGIT: begin
               // saturate at all ones
               id_in = (|id_x10[ID_W+3:ID_W]) ? '1 : id_x10[ID_W-1:0];
            end
            OP_TIME: begin
               start_in = start_ff + cmd.start_add;
               end_in   = end_ff + cmd.end_add;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff    <= '0;
         start_ff <= '0;
         end_ff   <= '0;
      end else begin
         id_ff    <= id_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

endmodule

// ----- hdl/subtitle_cue_stream_parser.sv -----
// Top level of the subtitle cue stream parser.
//
//  channel | ports                       | accepted when
//  --------+-----------------------------+---------------------
//  input   | req_push, req_full, req_*   | req_push && !req_full
//  result  | rsp_empty, rsp_pop, rsp_*   | rsp_pop && !rsp_empty
//
// One byte is taken per cycle while req_full is low; its result passes the front,
// the command queue, the back and the result queue, and is registered in both
// queues before it shows on the rsp_ ports and can be popped.
// The command queue of QUEUE_DEPTH entries sets req_full; the back stalls while
// the result queue is full. Synchronous reset clears phase, column, the cue
// fields and both queues.
`include "subtitle_cue_stream_parser_assert.svh"

module subtitle_cue_stream_parser
   import scp_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  logic [7:0]      req_char_in,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [1:0]      rsp_kind,
   output logic [7:0]      rsp_text_char,
   output logic [ID_W-1:0] rsp_cue_number,
   output logic [MS_W-1:0] rsp_start_ms,
   output logic [MS_W-1:0] rsp_end_ms
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   logic    front_enq;
   cmd_type front_cmd;
   logic    cmd_full, cmd_empty, cmd_pop;
   cmd_type cmd_head;
   logic    out_full, out_push;
   rsp_type out_item;
   rsp_type out_head;

   scp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .char_in    (req_char_in),
      .queue_full (cmd_full),
      .enq        (front_enq),
      .cmd        (front_cmd)
   );

   scp_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (front_enq),
      .din   (front_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .dout  (cmd_head),
      .empty (cmd_empty)
   );

   scp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (cmd_empty),
      .cmd         (cmd_head),
      .queue_pop   (cmd_pop),
      .rsp_full    (out_full),
      .rsp_push    (out_push),
      .rsp         (out_item)
   );

   scp_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_item),
      .full  (out_full),
      .pop   (rsp_pop),
      .dout  (out_head),
      .empty (rsp_empty)
   );

   assign req_full       = cmd_full;
   assign rsp_kind       = out_head.kind;
   assign rsp_text_char  = out_head.text_char;
   assign rsp_cue_number = out_head.cue_number;
   assign rsp_start_ms   = out_head.start_ms;
   assign rsp_end_ms     = out_head.end_ms;

   `SCP_ASSERT_IMPL(a_cmd_no_overflow, front_enq, !cmd_full, "command queue overflow")
   `SCP_ASSERT_IMPL(a_rsp_no_overflow, out_push, !out_full, "result queue overflow")
   `SCP_ASSERT_NEXT(a_enq_lands, front_enq, !cmd_empty, "queued item lost")
   `SCP_ASSERT_IMPL(a_no_text, !rsp_empty && rsp_kind != KIND_TEXT, rsp_text_char == '0, "stray")

endmodule

// ----- tb/subtitle_cue_stream_checker.sv -----
// Checker for the subtitle cue stream parser: predicts each result and compares popped ones.
module subtitle_cue_stream_checker
   import scp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   input  logic            req_full,
   input  logic [7:0]      req_char_in,
   input  logic            rsp_empty,
   input  logic            rsp_pop,
   input  logic [1:0]      rsp_kind,
   input  logic [7:0]      rsp_text_char,
   input  logic [ID_W-1:0] rsp_cue_number,
   input  logic [MS_W-1:0] rsp_start_ms,
   input  logic [MS_W-1:0] rsp_end_ms,
   output int              mismatch_count,
   output int              events_due
);

   phase_type       cur_phase;
   logic [5:0]      cur_column;
   logic [ID_W-1:0] cue_id;
   logic [MS_W-1:0] cue_start;
   logic [MS_W-1:0] cue_end;
   rsp_type         due_events[$];

   // Add one time digit at its place in "hh:mm:ss,mmm"; separators and stray bytes add nothing.
   function automatic logic [MS_W-1:0] add_time_digit(input logic [MS_W-1:0] acc,
                                                      input int offset,
                                                      input logic [7:0] ch);
      logic [MS_W-1:0] place;
      case (offset)
         0:       place = 29'd36000000;
         1:       place = 29'd3600000;
         3:       place = 29'd600000;
         4:       place = 29'd60000;
         6:       place = 29'd10000;
         7:       place = 29'd1000;
         9:       place = 29'd100;
         10:      place = 29'd10;
         11:      place = 29'd1;
         default: place = '0;
      endcase
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         return acc + place * MS_W'(ch - CHAR_ZERO);
      end
      return acc;
   endfunction

   // Queue one predicted result behind the others.
   task automatic note_due(input rsp_type ev);
      due_events.insert(due_events.size(), ev);
   endtask

   task automatic parse_byte(input logic [7:0] ch);
      rsp_type     ev;
      logic [5:0]  col;
      logic [35:0] wide;
      ev = '0;
      if (ch == NEWLINE) begin
         if (cur_column == 6'd0) begin
            // empty line closes the cue, whatever phase it arrives in
            ev.kind = KIND_CUE;
            ev.cue_number = cue_id;
            ev.start_ms = cue_start;
            ev.end_ms = cue_end;
            note_due(ev);
            cue_id = '0;
            cue_start = '0;
            cue_end = '0;
            cur_phase = PHASE_ID;
         end else begin
            cur_column = 6'd0;
            case (cur_phase)
               PHASE_TIME: cur_phase = PHASE_TEXT;
               PHASE_TEXT: begin
                  ev.kind = KIND_LINE_END;
                  note_due(ev);
               end
               default: cur_phase = PHASE_TIME;
            endcase
         end
      end else begin
         col = cur_column;
         if (cur_column != COLUMN_MAX) begin
            cur_column = cur_column + 6'd1;
         end
         case (cur_phase)
            PHASE_TEXT: begin
               ev.kind = KIND_TEXT;
               ev.text_char = ch;
               note_due(ev);
            end
            PHASE_TIME: begin
               cue_start = add_time_digit(cue_start, int'(col), ch);
               if (int'(col) >= END_TIME_COLUMN) begin
                  cue_end = add_time_digit(cue_end, int'(col) - END_TIME_COLUMN, ch);
               end
            end
            default: begin
               if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                  wide = 36'(cue_id) * 36'd10 + 36'(ch) - 36'(CHAR_ZERO);
                  cue_id = (wide > 36'hFFFFFFFF) ? '1 : wide[ID_W-1:0];
               end
            end
         endcase
      end
   endtask

   task automatic log_failure(input string why, input rsp_type want, input rsp_type seen);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected kind=%0d char=%0d cue=%0d start=%0d end=%0d,",
                  why, want.kind, want.text_char, want.cue_number, want.start_ms,
                  want.end_ms);
         $display("   got kind=%0d char=%0d cue=%0d start=%0d end=%0d",
                  seen.kind, seen.text_char, seen.cue_number, seen.start_ms, seen.end_ms);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         cur_phase = PHASE_ID;
         cur_column = 6'd0;
         cue_id = '0;
         cue_start = '0;
         cue_end = '0;
         due_events.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            seen.kind = kind_type'(rsp_kind);
            seen.text_char = rsp_text_char;
            seen.cue_number = rsp_cue_number;
            seen.start_ms = rsp_start_ms;
            seen.end_ms = rsp_end_ms;
            if (due_events.size() == 0) begin
               want = '0;
               log_failure("result with nothing due", want, seen);
            end else begin
               want = due_events.pop_front();
               if (seen.kind !== want.kind || seen.text_char !== want.text_char ||
                   seen.cue_number !== want.cue_number || seen.start_ms !== want.start_ms ||
                   seen.end_ms !== want.end_ms) begin
                  log_failure("mismatch", want, seen);
               end
            end
         end
         if (req_push && !req_full) begin
            parse_byte(req_char_in);
         end
      end
      events_due = due_events.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: feeds subtitle byte streams to the parser, pops results, gives the verdict.
module tb_top
   import scp_pkg::*;
();

   localparam int STREAM_LEN  = 730;
   localparam int STALL_LIMIT = 2000;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_push    = 1'b0;
   logic            req_full;
   logic [7:0]      req_char_in = 8'd0;
   logic            rsp_empty;
   logic            rsp_pop     = 1'b0;
   logic [1:0]      rsp_kind;
   logic [7:0]      rsp_text_char;
   logic [ID_W-1:0] rsp_cue_number;
   logic [MS_W-1:0] rsp_start_ms;
   logic [MS_W-1:0] rsp_end_ms;
   int              mismatch_count;
   int              events_due;
   bit              feed_done   = 1'b0;
   logic [7:0]      byte_stream[$];

   subtitle_cue_stream_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_in    (req_char_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_text_char  (rsp_text_char),
      .rsp_cue_number (rsp_cue_number),
      .rsp_start_ms   (rsp_start_ms),
      .rsp_end_ms     (rsp_end_ms)
   );

   subtitle_cue_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_in    (req_char_in),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_text_char  (rsp_text_char),
      .rsp_cue_number (rsp_cue_number),
      .rsp_start_ms   (rsp_start_ms),
      .rsp_end_ms     (rsp_end_ms),
      .mismatch_count (mismatch_count),
      .events_due     (events_due)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit take_gap(input bit calm);
      return !calm && ($urandom_range(99) < 38);
   endfunction

   function automatic logic [7:0] any_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == NEWLINE);
      return b;
   endfunction

   // Append one byte to the stream.
   task automatic add_byte(input logic [7:0] b);
      byte_stream.insert(byte_stream.size(), b);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   task automatic add_digit(input bit top_value, input int noise_pct);
      if ($urandom_range(99) < noise_pct) begin
         add_byte(any_byte());
      end else if (top_value) begin
         add_byte(CHAR_NINE);
      end else begin
         add_byte(8'(CHAR_ZERO + $urandom_range(9)));
      end
   endtask

   // Write "hh:mm:ss,mmm", digits all nines when top_value is set; a digit may be a random byte.
   task automatic add_stamp(input bit top_value);
      for (int i = 0; i < TIME_FIELD_LEN; i++) begin
         if (i == 2 || i == 5) begin
            add_byte(":");
         end else if (i == 8) begin
            add_byte(",");
         end else begin
            add_digit(top_value, 5);
         end
      end
   endtask

   task automatic add_cue();
      int shape;
      int n;
      shape = $urandom_range(99);
      n = (shape < 8) ? $urandom_range(11, 14) : $urandom_range(1, 4);
      repeat (n) add_digit(1'b0, 10);
      add_byte(NEWLINE);
      // cut the cue short where the timing line should be
      if (shape >= 92) begin
         add_byte(NEWLINE);
         return;
      end
      add_stamp(shape < 6);
      if (shape % 7 != 0) begin
         add_text(" --> ");
         add_stamp(shape < 6);
      end
      if (shape >= 10 && shape < 14) begin
         repeat (40) add_byte(any_byte());
      end
      add_byte(NEWLINE);
      repeat ($urandom_range(0, 2)) begin
         n = ($urandom_range(99) < 4) ? 70 : $urandom_range(1, 8);
         repeat (n) add_byte(any_byte());
         add_byte(NEWLINE);
      end
      add_byte(NEWLINE);
   endtask

   task automatic add_noise();
      repeat ($urandom_range(1, 12)) begin
         if ($urandom_range(99) < 15) begin
            add_byte(NEWLINE);
         end else begin
            add_byte(any_byte());
         end
      end
   endtask

   // Directed bytes first, then random cues with some noise.
   initial begin
      add_byte(NEWLINE);
      add_text("a7\n");
      add_text("99:99:99,999\n");
      add_byte(8'h0D);
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(NEWLINE);
      add_byte(NEWLINE);
      add_byte(8'h0D);
      add_byte(NEWLINE);
      add_byte(NEWLINE);
      while (byte_stream.size() < STREAM_LEN) begin
         if ($urandom_range(99) < 10) begin
            add_noise();
         end else begin
            add_cue();
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin : feed
      int idx;
      idx = 0;
      wait (!reset);
      @(negedge clock);
      while (idx < byte_stream.size()) begin
         if (take_gap(idx >= 300 && idx < 450)) begin
            req_push <= 1'b0;
         end else begin
            req_push <= 1'b1;
            req_char_in <= byte_stream[idx];
         end
         @(posedge clock);
         if (req_push && !req_full) begin
            idx++;
         end
         @(negedge clock);
      end
      req_push <= 1'b0;
      feed_done = 1'b1;
   end

   initial begin : drain
      int popped;
      popped = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         rsp_pop <= !take_gap(popped >= 250 && popped < 400);
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            popped++;
         end
      end
   end

   initial begin : verdict
      bit timed_out;
      int stall;
      timed_out = 1'b0;
      stall = 0;
      fork
         begin
            wait (feed_done);
            @(negedge clock);
            while (events_due != 0) @(negedge clock);
            repeat (10) @(posedge clock);
         end
         begin
            while (stall < STALL_LIMIT) begin
               @(posedge clock);
               if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
                  stall = 0;
               end else begin
                  stall++;
               end
            end
            timed_out = 1'b1;
         end
      join_any
      if (!timed_out && mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
